### design/stsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared widths, codes, types and fixed-point helpers of the transport sweep cell.
// ----------------------------------------------------------------------------
package stsc_pkg;

  localparam int NumCells = 1024;
  localparam int DataW    = 32;
  localparam int IdxW     = 10;
  localparam int ProdW    = 2 * DataW;
  localparam int RoundW   = ProdW - 16;
  localparam int WideW    = RoundW + 2;
  localparam int CfgIdxW  = 2;
  localparam int InTdataW  = 5 * DataW;
  localparam int OutFieldW = IdxW + 2 * DataW;
  localparam int OutTdataW = ((OutFieldW + 7) / 8) * 8;

  localparam logic signed [DataW-1:0] WeightReset = 32'sd65536;
  localparam logic signed [ProdW-1:0] RoundBias   = 64'sd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANGLE_WEIGHT = 2'd0,
    CFG_SWEEP_DIR    = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL_BOT,
    ST_AVG,
    ST_MUL_WGT,
    ST_FLUX
  } state_e;

  typedef struct packed {
    logic load;
    logic sum;
    logic mul_bot;
    logic avg;
    logic mul_wgt;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Q32.32 product to Q32.16 for a later Q16.16 saturation, round to nearest with ties toward +infinity.
  function automatic logic signed [RoundW-1:0] qround(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] b;
    b = p + RoundBias;
    return b[ProdW-1:16];
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic [WideW-DataW:0] top;
    top = v[WideW-1:DataW-1];
    if (top == '0 || top == '1) begin
      return v[DataW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

### design/stsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsc_ctrl
// Sequencer that steps one cell through the shared multiplier and adders.
// ----------------------------------------------------------------------------
module stsc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire stsc_pkg::status_t status_i,
  output stsc_pkg::cmd_t         cmd_o
);

  stsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stsc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = stsc_pkg::ST_SUM;
      end
      stsc_pkg::ST_SUM:     state_d = stsc_pkg::ST_MUL_BOT;
      stsc_pkg::ST_MUL_BOT: state_d = stsc_pkg::ST_AVG;
      stsc_pkg::ST_AVG:     state_d = stsc_pkg::ST_MUL_WGT;
      stsc_pkg::ST_MUL_WGT: state_d = stsc_pkg::ST_FLUX;
      stsc_pkg::ST_FLUX: begin
        if (status_i.out_free) state_d = stsc_pkg::ST_IDLE;
      end
      default: state_d = stsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      stsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      stsc_pkg::ST_SUM:     cmd_o.sum     = 1'b1;
      stsc_pkg::ST_MUL_BOT: cmd_o.mul_bot = 1'b1;
      stsc_pkg::ST_AVG:     cmd_o.avg     = 1'b1;
      stsc_pkg::ST_MUL_WGT: cmd_o.mul_wgt = 1'b1;
      stsc_pkg::ST_FLUX:    cmd_o.finish  = status_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### design/stsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsc_datapath
// Shared multiplier, saturating adders, sweep state and the result register.
// ----------------------------------------------------------------------------
module stsc_datapath #(
  parameter int NUM_CELLS = stsc_pkg::NumCells
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire stsc_pkg::cmd_t                       cmd_i,
  output stsc_pkg::status_t                         status_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [stsc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [stsc_pkg::DataW-1:0]           cfg_data_i,
  input  wire logic [stsc_pkg::InTdataW-1:0]        in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [stsc_pkg::OutTdataW-1:0]            out_data_o,
  output logic                                      out_last_o
);

  localparam int PosW  = $clog2(NUM_CELLS);
  localparam int DataW = stsc_pkg::DataW;
  localparam int IdxW  = stsc_pkg::IdxW;
  localparam int WideW = stsc_pkg::WideW;
  localparam logic [PosW-1:0] LastPos = PosW'(NUM_CELLS - 1);

  logic signed [DataW-1:0] weight_q;
  logic                    dir_q;
  logic signed [DataW-1:0] incoming_q;
  logic [PosW-1:0]         pos_q;

  logic signed [DataW-1:0] scat_q, src_q, bot_q, phi_q;
  logic signed [DataW-1:0] s_q, exit_q, avg_q;
  logic signed [stsc_pkg::ProdW-1:0] prod_q;

  logic signed [DataW-1:0] in_scat, in_src, in_top, in_bot, in_phi;
  logic signed [DataW-1:0] mul_a, mul_b;
  logic signed [DataW-1:0] s_d, exit_d, avg_d, flux_d;
  logic signed [DataW+1:0] avg_sum;
  logic [PosW-1:0]         idx_pos;
  logic [PosW+IdxW-1:0]    idx_ext;
  logic                    last_pos;

  logic                    out_valid_q;
  logic [IdxW-1:0]         out_idx_q;
  logic signed [DataW-1:0] out_avg_q, out_flux_q;
  logic                    out_last_q;

  assign in_scat = in_data_i[DataW-1:0];
  assign in_src  = in_data_i[2*DataW-1:DataW];
  assign in_top  = in_data_i[3*DataW-1:2*DataW];
  assign in_bot  = in_data_i[4*DataW-1:3*DataW];
  assign in_phi  = in_data_i[5*DataW-1:4*DataW];

  always_comb begin
    mul_a = incoming_q;
    mul_b = in_top;
    if (cmd_i.mul_bot) begin
      mul_a = s_q;
      mul_b = bot_q;
    end else if (cmd_i.mul_wgt) begin
      mul_a = weight_q;
      mul_b = avg_q;
    end
  end

  assign s_d = stsc_pkg::sat32(WideW'(scat_q) + WideW'(src_q)
                               + WideW'(stsc_pkg::qround(prod_q)));
  assign exit_d  = stsc_pkg::sat32(WideW'(stsc_pkg::qround(prod_q)));
  assign avg_sum = (DataW+2)'(incoming_q) + (DataW+2)'(exit_d) + 34'sd1;
  assign avg_d   = avg_sum[DataW:1];
  assign flux_d  = stsc_pkg::sat32(WideW'(phi_q) + WideW'(stsc_pkg::qround(prod_q)));

  assign last_pos = (pos_q == LastPos);
  assign idx_pos  = dir_q ? (LastPos - pos_q) : pos_q;
  assign idx_ext  = {{IdxW{1'b0}}, idx_pos};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.mul_bot || cmd_i.mul_wgt) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.load) begin
      scat_q <= in_scat;
      src_q  <= in_src;
      bot_q  <= in_bot;
      phi_q  <= in_phi;
    end
    if (cmd_i.sum) begin
      s_q <= s_d;
    end
    if (cmd_i.avg) begin
      exit_q <= exit_d;
      avg_q  <= avg_d;
    end
    if (cmd_i.finish) begin
      out_idx_q  <= idx_ext[IdxW-1:0];
      out_avg_q  <= avg_q;
      out_flux_q <= flux_d;
      out_last_q <= last_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= stsc_pkg::WeightReset;
      dir_q       <= 1'b0;
      incoming_q  <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          stsc_pkg::CFG_ANGLE_WEIGHT: weight_q <= cfg_data_i;
          stsc_pkg::CFG_SWEEP_DIR: begin
            dir_q      <= cfg_data_i[0];
            incoming_q <= '0;
            pos_q      <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        if (last_pos) begin
          incoming_q <= '0;
          pos_q      <= '0;
        end else begin
          incoming_q <= exit_q;
          pos_q      <= pos_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {{(stsc_pkg::OutTdataW - stsc_pkg::OutFieldW){1'b0}},
                        out_flux_q, out_avg_q, out_idx_q};

endmodule
`default_nettype wire

### design/slab_transport_sweep_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slab_transport_sweep_cell
// One-group, one-angle diamond difference sweep over a 1-D slab.
// ----------------------------------------------------------------------------
// One word in is one cell in sweep order; one word out follows for each cell.
// A cell is accepted in IDLE and then steps through SUM, MUL_BOT, AVG, MUL_WGT
// and FLUX; the next cell is accepted only after FLUX, which waits until the
// output register is free. The pace is set by the cell-to-cell recurrence,
// which runs three products through one shared 32x32 multiplier, each rounded
// and saturated, the first and last with an add. A finished word waits in the
// output register without holding up acceptance of the next cell. Writing the
// sweep direction restarts the sweep; the weight is read when a cell's average is multiplied.
module slab_transport_sweep_cell #(
  parameter int NUM_CELLS = stsc_pkg::NumCells
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [stsc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [stsc_pkg::DataW-1:0]         cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // scatter_term, external_source, top_coeff, bottom_coeff, flux_in
  input  wire logic [stsc_pkg::InTdataW-1:0]      s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // cell_index, cell_angular_flux, flux_out, zero padding
  output logic [stsc_pkg::OutTdataW-1:0]          m_axis_tdata,
  output logic                                    m_axis_tlast
);

  stsc_pkg::cmd_t    cmd;
  stsc_pkg::status_t status;

  stsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stsc_datapath #(
    .NUM_CELLS (NUM_CELLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  a_one_cell_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second cell accepted while one is in work");

  a_load_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load == (s_axis_tvalid && s_axis_tready))
    else $error("datapath load does not match input acceptance");

  a_finish_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over a word not yet taken");

  a_finish_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid)
    else $error("finished cell not presented at the output");

endmodule
`default_nettype wire

### tb/sv/tb_slab_transport_sweep_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slab_transport_sweep_cell
// Self-checking testbench for the 1-D slab diamond difference sweep cell.
// ----------------------------------------------------------------------------
// A short table of directed cells and register writes runs first. It is
// followed by random sweeps in both directions, the downward one crossing the
// end of a sweep, with weight changes in mid-sweep and direction changes that
// abort a sweep. Every accepted cell is run through a fixed-point model of the
// recurrence kept here, and each output word is compared field by field.
// Both stream sides idle and stall at random.
module tb_slab_transport_sweep_cell;
  import stsc_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 9;
  localparam int MaxGap      = 5;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 20;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef logic signed [DataW-1:0] q16_t;

  typedef struct packed {
    q16_t scatter;
    q16_t source;
    q16_t top;
    q16_t bottom;
    q16_t flux_in;
  } cell_word_t;

  typedef struct packed {
    logic [IdxW-1:0] index;
    q16_t            avg;
    q16_t            flux;
    logic            last;
  } cell_result_t;

  typedef enum logic {
    ROW_CELL,
    ROW_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_index;
    logic [DataW-1:0]    reg_value;
    cell_word_t          stim;
    bit                  pinned;
    cell_result_t        pinned_result;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [DataW-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  slab_transport_sweep_cell #(
    .NUM_CELLS(NumCells)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Model state of the sweep.
  q16_t   weight_now    = WeightReset;
  logic   dir_now       = 1'b0;
  longint incoming_now  = 0;
  int     position_now  = 0;

  cell_result_t awaited_cells[$];
  plan_row_t    plan[$];

  bit           steady      = 1'b0;
  logic         pin_valid   = 1'b0;
  cell_result_t pin_result  = '0;
  int           failures    = 0;
  int           cells_sent  = 0;
  int           sweeps_done = 0;
  int           reg_writes  = 0;
  int           idle_cycles = 0;
  bit           progress;
  cell_word_t   seen_cell;
  cell_result_t got_word;
  cell_result_t want_word;
  cell_result_t predicted;

  function automatic longint q16_mul(input longint a, input longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic cell_result_t diamond_step(input cell_word_t c);
    cell_result_t r;
    longint       s;
    longint       exiting;
    longint       avg;
    longint       flux;
    int           pos;
    pos = position_now;
    if (pos >= NumCells) pos = 0;
    r.last  = (pos == NumCells - 1);
    r.index = IdxW'(dir_now ? NumCells - 1 - pos : pos);
    s       = clamp32(longint'(c.scatter) + longint'(c.source) +
                      q16_mul(incoming_now, longint'(c.top)));
    exiting = clamp32(q16_mul(s, longint'(c.bottom)));
    avg     = (incoming_now + exiting + 1) >>> 1;
    flux    = clamp32(longint'(c.flux_in) + q16_mul(longint'(weight_now), avg));
    r.avg   = avg[DataW-1:0];
    r.flux  = flux[DataW-1:0];
    if (r.last) begin
      incoming_now = 0;
      position_now = 0;
    end else begin
      incoming_now = exiting;
      position_now = pos + 1;
    end
    return r;
  endfunction

  function automatic q16_t draw_q16(input bit coeff);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        if (coeff) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      end
    endcase
  endfunction

  function automatic plan_row_t cell_row(input q16_t sc, input q16_t src, input q16_t top,
                                         input q16_t bot, input q16_t phi,
                                         input bit pinned = 1'b0,
                                         input logic [IdxW-1:0] idx = '0,
                                         input q16_t avg = '0, input q16_t flux = '0,
                                         input logic last = 1'b0);
    plan_row_t row;
    row.kind          = ROW_CELL;
    row.reg_index     = '0;
    row.reg_value     = '0;
    row.stim          = '{sc, src, top, bot, phi};
    row.pinned        = pinned;
    row.pinned_result = '{idx, avg, flux, last};
    return row;
  endfunction

  function automatic plan_row_t write_row(input logic [CfgIdxW-1:0] idx,
                                          input logic [DataW-1:0] value);
    plan_row_t row;
    row.kind          = ROW_WRITE;
    row.reg_index     = idx;
    row.reg_value     = value;
    row.stim          = '0;
    row.pinned        = 1'b0;
    row.pinned_result = '0;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [DataW-1:0] want_v,
                             input logic [DataW-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: cell %0d %s expected %h actual %h", $time, want_word.index, name,
               want_v, got_v);
      failures++;
    end
  endtask

  // Predictor, scoreboard and watchdog all sample the pre-edge values.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      weight_now   = WeightReset;
      dir_now      = 1'b0;
      incoming_now = 0;
      position_now = 0;
      idle_cycles  = 0;
    end else begin
      progress = 1'b0;
      if (cfg_we_i) begin
        progress = 1'b1;
        reg_writes++;
        case (cfg_index_i)
          CFG_ANGLE_WEIGHT: weight_now = cfg_data_i;
          CFG_SWEEP_DIR: begin
            dir_now      = cfg_data_i[0];
            incoming_now = 0;
            position_now = 0;
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        progress = 1'b1;
        got_word = {m_axis_tdata[IdxW-1:0], m_axis_tdata[IdxW+DataW-1:IdxW],
                    m_axis_tdata[IdxW+2*DataW-1:IdxW+DataW], m_axis_tlast};
        if (got_word.last) sweeps_done++;
        if (awaited_cells.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, got_word);
          failures++;
        end else begin
          want_word = awaited_cells.pop_front();
          check_field("cell_index", DataW'(want_word.index), DataW'(got_word.index));
          check_field("cell_angular_flux", want_word.avg, got_word.avg);
          check_field("flux_out", want_word.flux, got_word.flux);
          check_field("last_cell", DataW'(want_word.last), DataW'(got_word.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        progress  = 1'b1;
        seen_cell = {s_axis_tdata[DataW-1:0], s_axis_tdata[2*DataW-1:DataW],
                     s_axis_tdata[3*DataW-1:2*DataW], s_axis_tdata[4*DataW-1:3*DataW],
                     s_axis_tdata[5*DataW-1:4*DataW]};
        predicted = diamond_step(seen_cell);
        awaited_cells.push_back(pin_valid ? pin_result : predicted);
        cells_sent++;
      end
      if (progress) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d words outstanding", $time,
                 StallLimit, awaited_cells.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_cell(input cell_word_t c, input bit pinned,
                           input cell_result_t pinned_res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.flux_in, c.bottom, c.top, c.source, c.scatter};
    pin_valid     <= pinned;
    pin_result    <= pinned_res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_cells.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random(input int count);
    cell_word_t c;
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      c.scatter = ($urandom_range(0, 3) == 0) ? '0 : draw_q16(1'b0);
      c.source  = draw_q16(1'b0);
      c.top     = draw_q16(1'b1);
      c.bottom  = draw_q16(1'b1);
      c.flux_in = draw_q16(1'b0);
      send_cell(c, 1'b0, '0);
    end
    steady = 1'b0;
  endtask

  initial begin
    plan.push_back(cell_row('0, '0, '0, '0, '0, 1'b1, 10'd0, '0, '0, 1'b0));
    plan.push_back(cell_row(32'h0001_0000, '0, '0, 32'h0001_0000, '0,
                            1'b1, 10'd1, 32'h0000_8000, 32'h0000_8000, 1'b0));
    plan.push_back(cell_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF));
    plan.push_back(cell_row('0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    plan.push_back(cell_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000));
    plan.push_back(cell_row('0, 32'h0002_0000, 32'h0000_8000, 32'h0000_4000, 32'h0003_0000));
    plan.push_back(write_row(CFG_ANGLE_WEIGHT, 32'h8000_0000));
    plan.push_back(cell_row(32'h0001_8000, 32'hFFFF_0000, 32'h0000_C000, 32'h0000_8000,
                            32'h7FFF_FFFF));
    plan.push_back(cell_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'h8000_0000));
    plan.push_back(write_row(CFG_ANGLE_WEIGHT, 32'h7FFF_FFFF));
    plan.push_back(cell_row(32'h0004_0000, '0, 32'h0001_0000, 32'h0000_8000, 32'h7FFF_0000));
    plan.push_back(write_row(CfgIdxUnused, 32'hFFFF_FFFF));
    plan.push_back(cell_row('0, 32'h0000_0001, '0, 32'h0000_8000, '0));
    plan.push_back(write_row(CFG_SWEEP_DIR, 32'h0000_0001));
    plan.push_back(cell_row('0, '0, '0, '0, '0, 1'b1, 10'd1023, '0, '0, 1'b0));
    plan.push_back(cell_row(32'h0002_0000, 32'h0001_0000, 32'hFFFF_8000, 32'h0000_C000,
                            32'hFFFE_0000));
    plan.push_back(write_row(CFG_ANGLE_WEIGHT, 32'h0000_0000));
    plan.push_back(cell_row('0, '0, '0, '0, 32'h1234_5678));
    plan.push_back(write_row(CFG_SWEEP_DIR, 32'h0000_0000));
    plan.push_back(write_row(CFG_ANGLE_WEIGHT, 32'h0001_0000));
    plan.push_back(cell_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
    plan.push_back(cell_row('0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000, '0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        send_cell(plan[i].stim, plan[i].pinned, plan[i].pinned_result);
      end
    end

    // The upward sweep runs partway; the weight changes halfway through.
    write_reg(CFG_ANGLE_WEIGHT, $urandom());
    write_reg(CFG_SWEEP_DIR, ($urandom() & ~32'h1));
    run_random(250);
    write_reg(CFG_ANGLE_WEIGHT, 32'h7FFF_FFFF);
    run_random(250);

    // The downward sweep is aborted once, then run past its last cell.
    write_reg(CFG_SWEEP_DIR, ($urandom() | 32'h1));
    write_reg(CFG_ANGLE_WEIGHT, 32'h8000_0000);
    run_random(60);
    write_reg(CfgIdxUnused, $urandom());
    write_reg(CFG_SWEEP_DIR, 32'h0000_0001);
    write_reg(CFG_ANGLE_WEIGHT, $urandom());
    run_random(1030);

    write_reg(CFG_ANGLE_WEIGHT, 32'h0000_0000);
    write_reg(CFG_SWEEP_DIR, 32'h0000_0000);
    run_random(20);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_cells.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Swept %0d cells with %0d register writes; %0d sweeps reached their last cell.",
             cells_sent, reg_writes, sweeps_done);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", failures);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
